// ----- rtl/stpp_pkg.sv -----
package stpp_pkg;

  localparam int NumSensorsDefault = 16;
  localparam int NumReadings       = 6;
  localparam int RawW              = 32;
  localparam int FracW             = 16;
  localparam int ReadW             = RawW + FracW;
  localparam int CountW            = 32;
  localparam int IdOutW            = 4;
  localparam int ShiftW            = 5;
  localparam int QueueDepth        = 2;

  localparam logic [ShiftW-1:0] ShiftReset = 5'd9;

  // configuration port
  localparam int PaddrW  = 3;
  localparam int RegIdxW = PaddrW - 2;
  localparam int PdataW  = 32;
  localparam logic [RegIdxW-1:0] RegDividerShift = '0;

  // request and result codes
  localparam logic OpByte     = 1'b0;
  localparam logic OpQuery    = 1'b1;
  localparam logic KindRecord = 1'b0;
  localparam logic KindQuery  = 1'b1;

  // characters
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChHexA       = 8'h41;
  localparam logic [7:0] ChHexF       = 8'h46;
  localparam logic [7:0] HexLetterOff = 8'd7;

  // stream packing
  localparam int InTdataW  = 16;
  localparam int OutPackW  = 1 + IdOutW + NumReadings * ReadW + CountW;
  localparam int OutTdataW = ((OutPackW + 7) / 8) * 8;

  typedef struct packed {
    logic                                kind;
    logic                                ok;
    logic                                in_store;
    logic [IdOutW-1:0]                   sensor_id;
    logic [NumReadings-1:0][RawW-1:0]    raw;
    logic [CountW-1:0]                   count;
  } cmd_t;

endpackage

// ----- rtl/sensor_text_packet_parser.sv -----
// Sensor text datagram parser.
// Slave stream: one datagram byte or one query per transfer. tuser selects
// the request (0 byte, 1 query), tlast marks the final byte of a datagram.
// Master stream: one result per datagram end (tuser 0, parsed record) and
// one per query (tuser 1, stored readings of query_id), in request order.
// Readings come out as signed fixed point, 16 fraction bits, scaled down
// by 2^divider_shift (APB register at address 0, reset value 9).
// A request passes the request queue, the staging register and the output
// register. Throughput: one request per cycle while s_axis_tready is high, set
// by the byte-wide parse step and the single write/read port of the reading table.
// Reset clears the parse state, the datagram counter and all sensor valid
// flags; the reading table itself is not cleared.
// When the receiver stalls, results hold in the output register, a staging
// register and a two-entry request queue; once those fill, s_axis_tready
// drops until the receiver takes a result.
module sensor_text_packet_parser import stpp_pkg::*; #(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // data_byte [7:0], query_id [11:8]
  input  logic                 s_axis_tlast,
  input  logic                 s_axis_tuser,  // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // ok, sensor_id, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, datagram_count
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,  // kind
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  output logic [PdataW-1:0]    prdata,
  output logic                 pready
);

  logic [ShiftW-1:0]                 shift_q;
  logic                              cfg_wr;
  logic                              push, pop, q_full, head_valid;
  cmd_t                              cmd, head;
  logic                              ok;
  logic [IdOutW-1:0]                 sensor_id;
  logic [NumReadings-1:0][ReadW-1:0] readings;
  logic [CountW-1:0]                 count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  paddr[PaddrW-1:2] == RegDividerShift;
  assign prdata = (paddr[PaddrW-1:2] == RegDividerShift) ? PdataW'(shift_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
    end else if (cfg_wr) begin
      shift_q <= pwdata[ShiftW-1:0];
    end
  end

  stpp_front #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .byte_i     (s_axis_tdata[7:0]),
    .last_i     (s_axis_tlast),
    .query_id_i (s_axis_tdata[8 +: IdOutW]),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  stpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  stpp_back #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .ok_o         (ok),
    .sensor_id_o  (sensor_id),
    .readings_o   (readings),
    .count_o      (count)
  );

  assign m_axis_tdata = {{(OutTdataW - OutPackW){1'b0}}, count, readings, sensor_id, ok};

endmodule

// ----- rtl/stpp_ram.sv -----
module stpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stpp_front.sv -----
module stpp_front import stpp_pkg::*; #(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [IdOutW-1:0] query_id_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  localparam int IdW    = $clog2(NUM_SENSORS + 1);
  localparam int IdSpan = 1 << IdOutW;
  localparam int StoreN = (NUM_SENSORS < IdSpan) ? NUM_SENSORS : IdSpan;
  localparam logic [2:0] TokDone = 3'(NumReadings + 1);

  typedef struct packed {
    logic [NumReadings-1:0][RawW-1:0] pend;
    logic [2:0]                       tok;
    logic                             in_tok;
    logic [IdW-1:0]                   id;
    logic [RawW-1:0]                  hex;
    logic                             ferr;
  } parse_t;

  function automatic parse_t take_char(parse_t s, logic [7:0] c);
    parse_t         r;
    logic [IdW+3:0] prod;
    logic [7:0]     off;
    logic [7:0]     let_off;
    logic [3:0]     dig;
    r       = s;
    off     = c - ChZero;
    let_off = c - ChZero - HexLetterOff;
    prod    = '0;
    dig     = '0;
    if (c == ChSpace) begin
      if (s.in_tok) begin
        for (int i = 0; i < NumReadings; i++) begin
          if (s.tok == 3'(i + 1)) begin
            r.pend[i] = s.hex;
          end
        end
        if (s.tok < TokDone) begin
          r.tok = s.tok + 3'd1;
        end
        r.in_tok = 1'b0;
      end
    end else begin
      if (!s.in_tok) begin
        r.in_tok = 1'b1;
        r.hex    = '0;
      end
      if (s.tok == 3'd0) begin
        if (c >= ChZero && c <= ChNine) begin
          // id*10 + digit, saturating at the sensor count
          prod = ({4'b0, s.id} << 3) + ({4'b0, s.id} << 1) + (IdW+4)'(off[3:0]);
          r.id = (prod > (IdW+4)'(NUM_SENSORS)) ? IdW'(NUM_SENSORS) : prod[IdW-1:0];
        end else begin
          r.ferr = 1'b1;
        end
      end else if (s.tok <= 3'(NumReadings)) begin
        if (c >= ChZero && c <= ChNine) begin
          dig = off[3:0];
        end else if (c >= ChHexA && c <= ChHexF) begin
          dig = let_off[3:0];
        end else begin
          r.ferr = 1'b1;
        end
        r.hex = {r.hex[RawW-5:0], dig};
      end
    end
    return r;
  endfunction

  parse_t            parse_q, parse_d;
  parse_t            after_byte, closed;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              rec_ok;
  logic [31:0]       id_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    after_byte = take_char(parse_q, byte_i);
    // the datagram end closes any open token
    closed     = take_char(after_byte, ChSpace);
    id_ext     = 32'(closed.id);
    rec_ok     = !closed.ferr && closed.tok >= TokDone && closed.id < IdW'(NUM_SENSORS);

    parse_d = parse_q;
    cnt_d   = cnt_q;
    if (accept && op_i == OpByte) begin
      if (last_i) begin
        parse_d = '0;
        cnt_d   = cnt_q + 32'd1;
      end else begin
        parse_d = after_byte;
      end
    end

    push_o = accept && (op_i == OpQuery || last_i);

    if (op_i == OpQuery) begin
      cmd_o.kind      = KindQuery;
      cmd_o.in_store  = 32'(query_id_i) < 32'(StoreN);
      cmd_o.ok        = cmd_o.in_store;
      cmd_o.sensor_id = query_id_i;
      cmd_o.raw       = '0;
      cmd_o.count     = cnt_q;
    end else begin
      cmd_o.kind      = KindRecord;
      cmd_o.ok        = rec_ok;
      cmd_o.in_store  = id_ext < 32'(StoreN);
      cmd_o.sensor_id = rec_ok ? id_ext[IdOutW-1:0] : '0;
      cmd_o.raw       = closed.pend;
      cmd_o.count     = cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= '0;
      cnt_q   <= '0;
    end else begin
      parse_q <= parse_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/stpp_queue.sv -----
module stpp_queue import stpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int AW   = $clog2(QueueDepth);
  localparam int CntW = AW + 1;

  cmd_t            mem_q [QueueDepth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = count_q == CntW'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("request queue underflow");

endmodule

// ----- rtl/stpp_back.sv -----
module stpp_back import stpp_pkg::*; #(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ShiftW-1:0]                 shift_i,
  input  logic                              head_valid_i,
  input  cmd_t                              head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              kind_o,
  output logic                              ok_o,
  output logic [IdOutW-1:0]                 sensor_id_o,
  output logic [NumReadings-1:0][ReadW-1:0] readings_o,
  output logic [CountW-1:0]                 count_o
);

  localparam int IdSpan = 1 << IdOutW;
  localparam int StoreN = (NUM_SENSORS < IdSpan) ? NUM_SENSORS : IdSpan;
  localparam int AddrW  = $clog2(StoreN);
  localparam int RowW   = NumReadings * ReadW;

  function automatic logic [ReadW-1:0] scale(logic [RawW-1:0] raw, logic [ShiftW-1:0] sh);
    logic signed [ReadW-1:0] v;
    v = $signed({raw, {FracW{1'b0}}});
    return v >>> sh;
  endfunction

  logic [NumReadings-1:0][ReadW-1:0] scaled;
  logic [AddrW-1:0]                  addr;
  logic [RowW-1:0]                   rdata;
  logic [StoreN-1:0]                 valid_q;
  logic                              we, re;
  logic                              s1_ready, out_ready;

  logic                              s1_valid_q, s1_valid_d;
  logic                              s1_kind_q, s1_ok_q;
  logic [IdOutW-1:0]                 s1_id_q;
  logic [CountW-1:0]                 s1_cnt_q;
  logic [NumReadings-1:0][ReadW-1:0] s1_read_q;

  logic                              out_valid_q, out_valid_d;
  logic                              out_kind_q, out_ok_q;
  logic [IdOutW-1:0]                 out_id_q;
  logic [CountW-1:0]                 out_cnt_q;
  logic [NumReadings-1:0][ReadW-1:0] out_read_q;

  always_comb begin
    for (int i = 0; i < NumReadings; i++) begin
      scaled[i] = scale(head_i.raw[i], shift_i);
    end
  end

  assign addr      = head_i.sensor_id[AddrW-1:0];
  assign out_ready = !out_valid_q || out_ready_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = head_valid_i && s1_ready;
  assign we        = pop_o && head_i.kind == KindRecord && head_i.ok && head_i.in_store;
  assign re        = pop_o && head_i.kind == KindQuery && head_i.in_store;

  assign s1_valid_d  = s1_ready ? pop_o : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  stpp_ram #(
    .WIDTH (RowW),
    .DEPTH (StoreN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (scaled),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[addr] <= 1'b1;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q <= head_i.kind;
      s1_ok_q   <= (head_i.kind == KindQuery) ? (head_i.in_store && valid_q[addr])
                                              : head_i.ok;
      s1_id_q   <= head_i.sensor_id;
      s1_cnt_q  <= head_i.count;
      s1_read_q <= (head_i.kind == KindRecord && head_i.ok) ? scaled : '0;
    end
    if (out_ready && s1_valid_q) begin
      out_kind_q <= s1_kind_q;
      out_ok_q   <= s1_ok_q;
      out_id_q   <= s1_id_q;
      out_cnt_q  <= s1_cnt_q;
      // query answers take the row read at pop time
      if (s1_kind_q == KindQuery) begin
        out_read_q <= s1_ok_q ? rdata : '0;
      end else begin
        out_read_q <= s1_read_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign ok_o        = out_ok_q;
  assign sensor_id_o = out_id_q;
  assign readings_o  = out_read_q;
  assign count_o     = out_cnt_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KindRecord && !out_ok_q |->
      out_read_q == '0 && out_id_q == '0)
    else $error("rejected record carries nonzero fields");

  a_query_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KindQuery && out_ok_q |->
      valid_q[out_id_q[AddrW-1:0]])
    else $error("query answered for an id never stored");

endmodule
